>>> sv/psc_pkg.sv
// Shared constants, register map and helpers for the pressure sensor compensation block.
package psc_pkg;

    localparam int unsigned DIV_W    = 32;
    localparam int unsigned NUM_REGS = 5;
    localparam int unsigned ADDR_W   = 5;
    localparam int unsigned IDX_W    = 3;

    localparam logic [IDX_W-1:0] REG_AC1_AC2 = 3'd0;
    localparam logic [IDX_W-1:0] REG_AC3_AC4 = 3'd1;
    localparam logic [IDX_W-1:0] REG_AC5_AC6 = 3'd2;
    localparam logic [IDX_W-1:0] REG_B1_B2   = 3'd3;
    localparam logic [IDX_W-1:0] REG_MC_MD   = 3'd4;

    localparam logic signed [31:0] T_OFFSET  = 32'sd4000;
    localparam logic signed [31:0] K_SQ      = 32'sd3038;
    localparam logic signed [31:0] K_LIN     = -32'sd7357;
    localparam logic signed [31:0] K_OFS     = 32'sd3791;
    localparam logic signed [31:0] B4_BIAS   = 32'sd32768;
    localparam logic [31:0]        B7_SCALE  = 32'd50000;
    localparam logic signed [31:0] T_MAX     = 32'sd32767;
    localparam logic signed [31:0] T_MIN     = -32'sd32768;
    localparam logic signed [31:0] P_MAX     = 32'sd1048575;

    // truncating (towards zero) signed division by 2**k
    function automatic logic signed [31:0] sdiv_p2(input logic signed [31:0] x,
                                                   input logic [4:0] k);
        logic signed [31:0] bias;
        bias = x[31] ? ((32'sd1 <<< k) - 32'sd1) : 32'sd0;
        return (x + bias) >>> k;
    endfunction

endpackage

>>> sv/psc_udiv.sv
// Pipelined restoring unsigned divider, one quotient bit per stage, with side payload.
module psc_udiv #(
    parameter int unsigned W  = psc_pkg::DIV_W,
    parameter int unsigned SW = 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [W-1:0]  n,
    input  logic [W-1:0]  d,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [W-1:0]  q,
    output logic [SW-1:0] side_out
);

    logic [W-1:0]  r_reg    [W];
    logic [W-1:0]  nq_reg   [W];
    logic [W-1:0]  d_reg    [W];
    logic [SW-1:0] side_reg [W];
    logic          v_reg    [W];

    for (genvar i = 0; i < W; i++) begin : g_st
        logic [W-1:0]  pr, pn, pd;
        logic [SW-1:0] ps;
        logic          pv;
        logic [W:0]    t;
        logic [W:0]    diff;
        logic          ge;

        if (i == 0) begin : g_first
            assign pr = '0;
            assign pn = n;
            assign pd = d;
            assign ps = side_in;
            assign pv = in_valid;
        end else begin : g_rest
            assign pr = r_reg[i-1];
            assign pn = nq_reg[i-1];
            assign pd = d_reg[i-1];
            assign ps = side_reg[i-1];
            assign pv = v_reg[i-1];
        end

        assign t    = {pr, pn[W-1]};
        assign diff = t - {1'b0, pd};
        assign ge   = (t >= {1'b0, pd});

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i] <= 1'b0;
            end else if (en) begin
                v_reg[i] <= pv;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[i]    <= ge ? diff[W-1:0] : t[W-1:0];
                nq_reg[i]   <= {pn[W-2:0], ge};
                d_reg[i]    <= pd;
                side_reg[i] <= ps;
            end
        end
    end

    assign out_valid = v_reg[W-1];
    assign q         = nq_reg[W-1];
    assign side_out  = side_reg[W-1];

endmodule

>>> sv/pressure_sensor_compensation_top.sv
// Top level: APB coefficient registers and the compensation pipeline.
// Path from input transaction to result on m_tvalid: 3 front stages, 32-stage
// temperature divider, 7 stages, 32-stage pressure divider, 2 stages, output register.
// Throughput: one transaction per cycle unless a blocked result stalls the pipeline;
// the two pipelined dividers set the depth. Synchronous active-low reset clears the
// coefficients to zero and empties the pipeline.
module pressure_sensor_compensation_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [31:0]                 s_tdata,  // raw_temperature[15:0], raw_pressure[31:16]
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [39:0]                 m_tdata,  // temperature_tenths[15:0], pressure_pa[35:16]
    output logic [0:0]                  m_tuser,  // divide_fault[0]
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [psc_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int unsigned D1_SW = 50;
    localparam int unsigned D2_SW = 18;

    // ---------------- configuration ----------------
    logic [31:0] coef_reg [psc_pkg::NUM_REGS];
    logic [psc_pkg::IDX_W-1:0] widx;

    assign pready = 1'b1;
    assign widx   = paddr[psc_pkg::ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < psc_pkg::NUM_REGS; i++) coef_reg[i] <= '0;
        end else if (psel && penable && pwrite &&
                     (widx < psc_pkg::IDX_W'(psc_pkg::NUM_REGS))) begin
            coef_reg[widx] <= pwdata;
        end
    end

    always_comb begin
        prdata = '0;
        if (widx < psc_pkg::IDX_W'(psc_pkg::NUM_REGS)) prdata = coef_reg[widx];
    end

    logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md;
    logic        [31:0] ac4, ac5, ac6;

    assign ac1 = 32'(signed'(coef_reg[psc_pkg::REG_AC1_AC2][31:16]));
    assign ac2 = 32'(signed'(coef_reg[psc_pkg::REG_AC1_AC2][15:0]));
    assign ac3 = 32'(signed'(coef_reg[psc_pkg::REG_AC3_AC4][31:16]));
    assign ac4 = {16'd0, coef_reg[psc_pkg::REG_AC3_AC4][15:0]};
    assign ac5 = {16'd0, coef_reg[psc_pkg::REG_AC5_AC6][31:16]};
    assign ac6 = {16'd0, coef_reg[psc_pkg::REG_AC5_AC6][15:0]};
    assign b1  = 32'(signed'(coef_reg[psc_pkg::REG_B1_B2][31:16]));
    assign b2  = 32'(signed'(coef_reg[psc_pkg::REG_B1_B2][15:0]));
    assign mc  = 32'(signed'(coef_reg[psc_pkg::REG_MC_MD][31:16]));
    assign md  = 32'(signed'(coef_reg[psc_pkg::REG_MC_MD][15:0]));

    // ---------------- flow control ----------------
    logic m_tvalid_reg;
    logic s13_valid_reg;
    logic en;

    // pipeline stalls only when a finished item has nowhere to go
    assign en       = !(m_tvalid_reg && !m_tready) || !s13_valid_reg;
    assign s_tready = en;

    // ---------------- stage 1: (UT - AC6) * AC5 ----------------
    logic        s1_valid_reg;
    logic [31:0] s1_prod_reg;
    logic [15:0] s1_up_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) s1_valid_reg <= 1'b0;
        else if (en)  s1_valid_reg <= s_tvalid;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_prod_reg <= ({16'd0, s_tdata[15:0]} - ac6) * ac5;
            s1_up_reg   <= s_tdata[31:16];
        end
    end

    // ---------------- stage 2: X1, denominator ----------------
    logic               s2_valid_reg;
    logic signed [31:0] s2_x1_reg, s2_den_reg;
    logic        [15:0] s2_up_reg;
    logic signed [31:0] s2_x1_next;

    assign s2_x1_next = signed'(s1_prod_reg) >>> 15;

    always_ff @(posedge aclk) begin
        if (!aresetn) s2_valid_reg <= 1'b0;
        else if (en)  s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_x1_reg  <= s2_x1_next;
            s2_den_reg <= s2_x1_next + md;
            s2_up_reg  <= s1_up_reg;
        end
    end

    // ---------------- stage 3: magnitudes for the temperature divider ----------------
    logic               s3_valid_reg;
    logic        [31:0] s3_nmag_reg, s3_dmag_reg;
    logic signed [31:0] s3_x1_reg;
    logic               s3_neg_reg, s3_fault_reg;
    logic        [15:0] s3_up_reg;
    logic signed [31:0] num;

    assign num = mc <<< 11;

    always_ff @(posedge aclk) begin
        if (!aresetn) s3_valid_reg <= 1'b0;
        else if (en)  s3_valid_reg <= s2_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_nmag_reg  <= num[31] ? 32'(-num) : num;
            s3_dmag_reg  <= s2_den_reg[31] ? 32'(-s2_den_reg) : s2_den_reg;
            s3_neg_reg   <= num[31] ^ s2_den_reg[31];
            s3_fault_reg <= (s2_den_reg == 32'sd0);
            s3_x1_reg    <= s2_x1_reg;
            s3_up_reg    <= s2_up_reg;
        end
    end

    logic             d1_valid;
    logic [31:0]      d1_q;
    logic [D1_SW-1:0] d1_side;

    psc_udiv #(.W(psc_pkg::DIV_W), .SW(D1_SW)) u_tdiv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s3_valid_reg),
        .n         (s3_nmag_reg),
        .d         (s3_dmag_reg),
        .side_in   ({s3_x1_reg, s3_neg_reg, s3_fault_reg, s3_up_reg}),
        .out_valid (d1_valid),
        .q         (d1_q),
        .side_out  (d1_side)
    );

    // ---------------- stage 4: B5, T, B6 ----------------
    logic               s4_valid_reg;
    logic signed [31:0] s4_b6_reg;
    logic        [15:0] s4_t_reg;
    logic               s4_fault_reg;
    logic        [15:0] s4_up_reg;
    logic signed [31:0] x2_t, b5, tq, tsat;

    assign x2_t = d1_side[17] ? 32'(-signed'(d1_q)) : signed'(d1_q);
    assign b5   = signed'(d1_side[49:18]) + x2_t;
    assign tq   = psc_pkg::sdiv_p2(b5 + 32'sd8, 5'd4);

    always_comb begin
        tsat = tq;
        if (tq > psc_pkg::T_MAX) tsat = psc_pkg::T_MAX;
        if (tq < psc_pkg::T_MIN) tsat = psc_pkg::T_MIN;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) s4_valid_reg <= 1'b0;
        else if (en)  s4_valid_reg <= d1_valid;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s4_b6_reg    <= b5 - psc_pkg::T_OFFSET;
            s4_t_reg     <= tsat[15:0];
            s4_fault_reg <= d1_side[16];
            s4_up_reg    <= d1_side[15:0];
        end
    end

    // ---------------- stage 5: B6 products ----------------
    logic               s5_valid_reg;
    logic signed [31:0] s5_sqp_reg, s5_mac2_reg, s5_mac3_reg;
    logic        [15:0] s5_t_reg, s5_up_reg;
    logic               s5_fault_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) s5_valid_reg <= 1'b0;
        else if (en)  s5_valid_reg <= s4_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s5_sqp_reg   <= s4_b6_reg * s4_b6_reg;
            s5_mac2_reg  <= ac2 * s4_b6_reg;
            s5_mac3_reg  <= ac3 * s4_b6_reg;
            s5_t_reg     <= s4_t_reg;
            s5_up_reg    <= s4_up_reg;
            s5_fault_reg <= s4_fault_reg;
        end
    end

    // ---------------- stage 6: scaling ----------------
    logic               s6_valid_reg;
    logic signed [31:0] s6_sq_reg, s6_x2a_reg, s6_x1c_reg;
    logic        [15:0] s6_t_reg, s6_up_reg;
    logic               s6_fault_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) s6_valid_reg <= 1'b0;
        else if (en)  s6_valid_reg <= s5_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s6_sq_reg    <= psc_pkg::sdiv_p2(s5_sqp_reg, 5'd12);
            s6_x2a_reg   <= psc_pkg::sdiv_p2(s5_mac2_reg, 5'd11);
            s6_x1c_reg   <= psc_pkg::sdiv_p2(s5_mac3_reg, 5'd13);
            s6_t_reg     <= s5_t_reg;
            s6_up_reg    <= s5_up_reg;
            s6_fault_reg <= s5_fault_reg;
        end
    end

    // ---------------- stage 7: B2*sq, B1*sq ----------------
    logic               s7_valid_reg;
    logic signed [31:0] s7_mb2_reg, s7_mb1_reg, s7_x2a_reg, s7_x1c_reg;
    logic        [15:0] s7_t_reg, s7_up_reg;
    logic               s7_fault_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) s7_valid_reg <= 1'b0;
        else if (en)  s7_valid_reg <= s6_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s7_mb2_reg   <= b2 * s6_sq_reg;
            s7_mb1_reg   <= b1 * s6_sq_reg;
            s7_x2a_reg   <= s6_x2a_reg;
            s7_x1c_reg   <= s6_x1c_reg;
            s7_t_reg     <= s6_t_reg;
            s7_up_reg    <= s6_up_reg;
            s7_fault_reg <= s6_fault_reg;
        end
    end

    // ---------------- stage 8: B3 and the B4 multiplicand ----------------
    logic               s8_valid_reg;
    logic signed [31:0] s8_b3_reg, s8_s_reg;
    logic        [15:0] s8_t_reg, s8_up_reg;
    logic               s8_fault_reg;
    logic signed [31:0] x3_b3, x2_b4, x3_b4;

    assign x3_b3 = psc_pkg::sdiv_p2(s7_mb2_reg, 5'd11) + s7_x2a_reg;
    assign x2_b4 = psc_pkg::sdiv_p2(s7_mb1_reg, 5'd16);
    assign x3_b4 = psc_pkg::sdiv_p2(s7_x1c_reg + x2_b4 + 32'sd2, 5'd2);

    always_ff @(posedge aclk) begin
        if (!aresetn) s8_valid_reg <= 1'b0;
        else if (en)  s8_valid_reg <= s7_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s8_b3_reg    <= psc_pkg::sdiv_p2((ac1 <<< 2) + x3_b3 + 32'sd2, 5'd2);
            s8_s_reg     <= x3_b4 + psc_pkg::B4_BIAS;
            s8_t_reg     <= s7_t_reg;
            s8_up_reg    <= s7_up_reg;
            s8_fault_reg <= s7_fault_reg;
        end
    end

    // ---------------- stage 9: B4, UP - B3 ----------------
    logic        s9_valid_reg;
    logic [16:0] s9_b4_reg;
    logic [31:0] s9_b7d_reg;
    logic [15:0] s9_t_reg;
    logic        s9_fault_reg;
    logic [31:0] b4_prod;

    assign b4_prod = ac4 * unsigned'(s8_s_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) s9_valid_reg <= 1'b0;
        else if (en)  s9_valid_reg <= s8_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s9_b4_reg    <= b4_prod[31:15];
            s9_b7d_reg   <= {16'd0, s8_up_reg} - unsigned'(s8_b3_reg);
            s9_t_reg     <= s8_t_reg;
            s9_fault_reg <= s8_fault_reg;
        end
    end

    // ---------------- stage 10: B7 ----------------
    logic        s10_valid_reg;
    logic [31:0] s10_b7_reg;
    logic [16:0] s10_b4_reg;
    logic [15:0] s10_t_reg;
    logic        s10_fault_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) s10_valid_reg <= 1'b0;
        else if (en)  s10_valid_reg <= s9_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s10_b7_reg    <= s9_b7d_reg * psc_pkg::B7_SCALE;
            s10_b4_reg    <= s9_b4_reg;
            s10_t_reg     <= s9_t_reg;
            s10_fault_reg <= s9_fault_reg || (s9_b4_reg == 17'd0);
        end
    end

    // ---------------- pressure divider ----------------
    logic             d2_valid;
    logic [31:0]      d2_q;
    logic [D2_SW-1:0] d2_side;
    logic [31:0]      d2_n;

    // large B7 is divided first and doubled after, as in the published algorithm
    assign d2_n = s10_b7_reg[31] ? s10_b7_reg : {s10_b7_reg[30:0], 1'b0};

    psc_udiv #(.W(psc_pkg::DIV_W), .SW(D2_SW)) u_pdiv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s10_valid_reg),
        .n         (d2_n),
        .d         ({15'd0, s10_b4_reg}),
        .side_in   ({s10_t_reg, s10_fault_reg, s10_b7_reg[31]}),
        .out_valid (d2_valid),
        .q         (d2_q),
        .side_out  (d2_side)
    );

    // ---------------- stage 12: p terms ----------------
    logic               s12_valid_reg;
    logic signed [31:0] s12_p_reg, s12_x1_reg, s12_m2_reg;
    logic        [15:0] s12_t_reg;
    logic               s12_fault_reg;
    logic signed [31:0] p0, pa;

    assign p0 = d2_side[0] ? signed'({d2_q[30:0], 1'b0}) : signed'(d2_q);
    assign pa = psc_pkg::sdiv_p2(p0, 5'd8);

    always_ff @(posedge aclk) begin
        if (!aresetn) s12_valid_reg <= 1'b0;
        else if (en)  s12_valid_reg <= d2_valid;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s12_p_reg     <= p0;
            s12_x1_reg    <= pa * pa;
            s12_m2_reg    <= psc_pkg::K_LIN * p0;
            s12_t_reg     <= d2_side[17:2];
            s12_fault_reg <= d2_side[1];
        end
    end

    // ---------------- stage 13 ----------------
    logic signed [31:0] s13_p_reg, s13_x1_reg, s13_x2_reg;
    logic        [15:0] s13_t_reg;
    logic               s13_fault_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) s13_valid_reg <= 1'b0;
        else if (en)  s13_valid_reg <= s12_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s13_p_reg     <= s12_p_reg;
            s13_x1_reg    <= s12_x1_reg * psc_pkg::K_SQ;
            s13_x2_reg    <= psc_pkg::sdiv_p2(s12_m2_reg, 5'd16);
            s13_t_reg     <= s12_t_reg;
            s13_fault_reg <= s12_fault_reg;
        end
    end

    // ---------------- final correction and output register ----------------
    logic signed [31:0] pf, psat;
    logic        [15:0] m_temp_reg;
    logic        [19:0] m_pres_reg;
    logic               m_fault_reg;

    assign pf = s13_p_reg + psc_pkg::sdiv_p2(psc_pkg::sdiv_p2(s13_x1_reg, 5'd16)
                + s13_x2_reg + psc_pkg::K_OFS, 5'd4);

    always_comb begin
        psat = pf;
        if (pf < 32'sd0)         psat = 32'sd0;
        if (pf > psc_pkg::P_MAX) psat = psc_pkg::P_MAX;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en && s13_valid_reg) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && s13_valid_reg) begin
            m_temp_reg  <= s13_fault_reg ? 16'd0 : s13_t_reg;
            m_pres_reg  <= s13_fault_reg ? 20'd0 : psat[19:0];
            m_fault_reg <= s13_fault_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, m_pres_reg, m_temp_reg};
    assign m_tuser  = m_fault_reg;

    // ---------------- assertions ----------------
    a_fault_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> (m_tdata[35:0] == 36'd0))
        else $error("fault transaction carries non-zero results");

    a_ready_only_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && s13_valid_reg)
        else $error("input stalled without a blocked result");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(s13_valid_reg) && $stable(s13_p_reg))
        else $error("last stage changed during stall");

    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(s13_valid_reg))
        else $error("result appeared without a valid item");

endmodule

>>> bench/pressure_sensor_compensation_checker.sv
`timescale 1ns / 1ps
// Channel monitor, compensation predictor and result scoreboard for the compensation block.
module pressure_sensor_compensation_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [31:0]                 s_tdata,  // raw_temperature[15:0], raw_pressure[31:16]
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [39:0]                 m_tdata,  // temperature_tenths[15:0], pressure_pa[35:16]
    input  logic [0:0]                  m_tuser,  // divide_fault[0]
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic                        pready,
    input  logic [psc_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output int                          fail_count,
    output int                          pending,
    output int                          results_seen,
    output int                          faults_seen
);

    typedef struct packed {
        logic signed [15:0] temp_tenths;
        logic [19:0]        pressure;
        logic               fault;
    } reading_t;

    logic [31:0] coef [psc_pkg::NUM_REGS];
    reading_t    expected_q[$];

    // truncating division, quotient wraps to 32 bits
    function automatic int tdiv(int n, int d);
        longint q;
        q = longint'(n) / longint'(d);
        return int'(q[31:0]);
    endfunction

    function automatic reading_t compensate(logic [15:0] ut_raw, logic [15:0] up_raw);
        int ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md, ut;
        int x1, x2, x3, b5, b6, b3, sq, t, p, den;
        int unsigned b4, b7, pu;
        reading_t r;
        ac1 = int'(signed'(coef[psc_pkg::REG_AC1_AC2][31:16]));
        ac2 = int'(signed'(coef[psc_pkg::REG_AC1_AC2][15:0]));
        ac3 = int'(signed'(coef[psc_pkg::REG_AC3_AC4][31:16]));
        ac4 = int'({16'd0, coef[psc_pkg::REG_AC3_AC4][15:0]});
        ac5 = int'({16'd0, coef[psc_pkg::REG_AC5_AC6][31:16]});
        ac6 = int'({16'd0, coef[psc_pkg::REG_AC5_AC6][15:0]});
        b1  = int'(signed'(coef[psc_pkg::REG_B1_B2][31:16]));
        b2  = int'(signed'(coef[psc_pkg::REG_B1_B2][15:0]));
        mc  = int'(signed'(coef[psc_pkg::REG_MC_MD][31:16]));
        md  = int'(signed'(coef[psc_pkg::REG_MC_MD][15:0]));
        ut  = int'({16'd0, ut_raw});
        r = '{temp_tenths: '0, pressure: '0, fault: 1'b1};

        x1 = ((ut - ac6) * ac5) >>> 15;
        den = x1 + md;
        if (den == 0) return r;
        x2 = tdiv(mc * 2048, den);
        b5 = x1 + x2;
        t  = tdiv(b5 + 8, 16);

        b6 = b5 - 4000;
        sq = tdiv(b6 * b6, 4096);
        x1 = tdiv(b2 * sq, 2048);
        x2 = tdiv(ac2 * b6, 2048);
        x3 = x1 + x2;
        b3 = tdiv(ac1 * 4 + x3 + 2, 4);
        x1 = tdiv(ac3 * b6, 8192);
        x2 = tdiv(b1 * sq, 65536);
        x3 = tdiv(x1 + x2 + 2, 4);
        b4 = (unsigned'(ac4) * unsigned'(x3 + 32768)) >> 15;
        if (b4 == 0) return r;
        b7 = ({16'd0, up_raw} - unsigned'(b3)) * 32'd50000;
        if (b7 < 32'h8000_0000) pu = (b7 * 2) / b4;
        else pu = (b7 / b4) * 2;
        p = int'(pu);

        x1 = tdiv(p, 256);
        x1 = x1 * x1;
        x1 = tdiv(x1 * 3038, 65536);
        x2 = tdiv(-7357 * p, 65536);
        p  = p + tdiv(x1 + x2 + 3791, 16);

        if (t > 32767) t = 32767;
        if (t < -32768) t = -32768;
        if (p < 0) p = 0;
        if (p > 1048575) p = 1048575;
        r.temp_tenths = t[15:0];
        r.pressure    = p[19:0];
        r.fault       = 1'b0;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    assign pending = expected_q.size();

    initial begin
        fail_count   = 0;
        results_seen = 0;
        faults_seen  = 0;
    end

    always @(posedge aclk) begin
        reading_t want;
        if (!aresetn) begin
            for (int i = 0; i < psc_pkg::NUM_REGS; i++) coef[i] <= '0;
        end else begin
            if (psel && penable && pwrite && pready &&
                paddr[psc_pkg::ADDR_W-1:2] < psc_pkg::NUM_REGS)
                coef[paddr[psc_pkg::ADDR_W-1:2]] <= pwdata;
            if (s_tvalid && s_tready)
                expected_q.push_back(compensate(s_tdata[15:0], s_tdata[31:16]));
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected transaction, tdata", m_tdata, 0);
                end else begin
                    want = expected_q.pop_front();
                    if (want.fault) faults_seen++;
                    if (m_tdata[15:0] !== want.temp_tenths)
                        report_mismatch("temperature_tenths", signed'(m_tdata[15:0]),
                                        want.temp_tenths);
                    if (m_tdata[35:16] !== want.pressure)
                        report_mismatch("pressure_pa", m_tdata[35:16], want.pressure);
                    if (m_tuser[0] !== want.fault)
                        report_mismatch("divide_fault", m_tuser[0], want.fault);
                end
            end
        end
    end

endmodule

>>> bench/pressure_sensor_compensation_top_test.sv
`timescale 1ns / 1ps
// Stimulus, clock, reset and verdict for the pressure sensor compensation block.
module pressure_sensor_compensation_top_test;

    localparam int CYCLE_LIMIT = 300000;
    localparam int PIPE_DRAIN  = 100;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [psc_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0, prdata;
    logic        pready;

    int fail_count, pending, results_seen, faults_seen;
    int idle_mode = 0;      // 0 none, 1 sender, 2 receiver, 3 both
    int hold_cycles = 0;    // long receiver hold-off request
    int cycle_count = 0;
    int items_sent = 0;

    pressure_sensor_compensation_top dut (.*);

    pressure_sensor_compensation_checker checker_i (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout with %0d transactions outstanding", pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result side ready pattern, plus the long hold-off
    always @(posedge aclk) begin
        if (hold_cycles > 0) begin
            m_tready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else if (idle_mode == 2) begin
            m_tready <= ($urandom_range(99) >= 52);
        end else if (idle_mode == 3) begin
            m_tready <= ($urandom_range(99) >= 30);
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic apb_write(logic [2:0] idx, logic [31:0] value);
        @(posedge aclk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= psc_pkg::ADDR_W'(idx) << 2; pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    task automatic send_reading(logic [15:0] ut, logic [15:0] up);
        int gap;
        gap = 0;
        // each cycle idle with the phase's probability
        if (idle_mode == 1) while ($urandom_range(99) < 52) gap++;
        if (idle_mode == 3) while ($urandom_range(99) < 30) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {up, ut};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (PIPE_DRAIN) @(posedge aclk);
    endtask

    task automatic load_coefs(logic [31:0] c0, c1, c2, c3, c4);
        apb_write(psc_pkg::REG_AC1_AC2, c0);
        apb_write(psc_pkg::REG_AC3_AC4, c1);
        apb_write(psc_pkg::REG_AC5_AC6, c2);
        apb_write(psc_pkg::REG_B1_B2, c3);
        apb_write(psc_pkg::REG_MC_MD, c4);
    endtask

    task automatic random_readings(int count);
        logic [15:0] ut, up;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(1)) begin
                ut = 16'($urandom());
                up = 16'($urandom());
            end else begin
                // plausible readings around room temperature and sea level
                ut = 16'(27898 + int'($urandom_range(8000)) - 4000);
                up = 16'(23843 + int'($urandom_range(8000)) - 4000);
            end
            send_reading(ut, up);
        end
    endtask

    // calibration set of a typical sensor
    localparam logic [31:0] CAL0 = {16'sd408, -16'sd72};
    localparam logic [31:0] CAL1 = {-16'sd14383, 16'd32741};
    localparam logic [31:0] CAL2 = {16'd32757, 16'd23153};
    localparam logic [31:0] CAL3 = {16'sd6190, 16'sd4};
    localparam logic [31:0] CAL4 = {-16'sd8711, 16'sd2868};

    initial begin
        logic [31:0] r0, r1, r2, r3, r4;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset coefficients: temperature divisor is zero
        send_reading(16'd27898, 16'd23843);
        send_reading(16'hFFFF, 16'h0000);
        drain_pipeline();

        load_coefs(CAL0, CAL1, CAL2, CAL3, CAL4);
        apb_write(3'd5, $urandom());    // past the register map, ignored
        apb_write(3'd7, $urandom());
        send_reading(16'd27898, 16'd23843);
        send_reading(16'h0000, 16'h0000);
        send_reading(16'hFFFF, 16'hFFFF);
        send_reading(16'h0000, 16'hFFFF);
        send_reading(16'hFFFF, 16'h0000);
        send_reading(16'hAAAA, 16'h5555);
        send_reading(16'h5555, 16'hAAAA);
        send_reading(16'd23153, 16'd40000);
        drain_pipeline();

        // zero pressure divisor
        load_coefs(CAL0, {CAL1[31:16], 16'd0}, CAL2, CAL3, CAL4);
        send_reading(16'd27898, 16'd23843);
        send_reading(16'd30000, 16'd100);
        drain_pipeline();

        // large MC pushes temperature and pressure to their limits
        load_coefs(CAL0, CAL1, CAL2, CAL3, {16'h7FFF, 16'sd1});
        send_reading(16'd23200, 16'd23843);
        send_reading(16'd23100, 16'hFFFF);
        send_reading(16'd27898, 16'd0);
        drain_pipeline();

        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: load_coefs(CAL0, CAL1, CAL2, CAL3, CAL4);
                1: load_coefs('1, '1, '1, '1, '1);
                2: load_coefs(32'h8000_8000, 32'h8000_8000, 32'h8000_8000,
                              32'h8000_8000, 32'h8000_8000);
                3: load_coefs(32'h7FFF_7FFF, 32'h7FFF_7FFF, 32'h7FFF_7FFF,
                              32'h7FFF_7FFF, 32'h7FFF_7FFF);
                4, 5: begin
                    r0 = CAL0 ^ ($urandom() & 32'h00FF_00FF);
                    r1 = CAL1 ^ ($urandom() & 32'h00FF_0FFF);
                    r2 = CAL2 ^ ($urandom() & 32'h00FF_0FFF);
                    r3 = CAL3 ^ ($urandom() & 32'h00FF_000F);
                    r4 = CAL4 ^ ($urandom() & 32'h00FF_00FF);
                    load_coefs(r0, r1, r2, r3, r4);
                end
                default: load_coefs($urandom(), $urandom(), $urandom(), $urandom(),
                                    $urandom());
            endcase
            idle_mode = phase % 4;
            if (phase == 4) begin
                hold_cycles <= 300;     // block fills up and back-pressures its input
                random_readings(60);
            end
            random_readings(phase < 4 ? 200 : 180);
            drain_pipeline();
        end
        idle_mode = 0;

        $display("%0d readings sent, %0d results checked, %0d with a divide fault",
                 items_sent, results_seen, faults_seen);
        $display("coefficient sets: reset, typical, zero divisors, saturation, extremes, random");
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
